### hw/rtl/matching_union_cycle_check_top_macros.svh
// Assertion macros for the matching union cycle check block.
`ifndef MATCHING_UNION_CYCLE_CHECK_TOP_MACROS_SVH
`define MATCHING_UNION_CYCLE_CHECK_TOP_MACROS_SVH

// Check an implication in the same cycle, off while in reset.
`define MUCC_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Check an implication in the next cycle, off while in reset.
`define MUCC_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

### hw/rtl/mucc_pkg.sv
// Shared constants, types and command/status structs for the matching union cycle check.
package mucc_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int VERTEX_W     = 5;
   localparam int ADDR_W       = $clog2(MAX_VERTICES);
   localparam int COUNT_W      = 6;
   localparam int MASK_W       = 33;
   localparam int CYCLES_W     = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 33;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_VERTEX_COUNT   = 2'd0;
   localparam csr_index_type CSR_ALLOWED_MASK   = 2'd1;
   localparam csr_index_type CSR_EXPECTED_COUNT = 2'd2;

   localparam logic [COUNT_W-1:0]  VERTEX_COUNT_RESET   = 6'd32;
   localparam logic [MASK_W-1:0]   ALLOWED_MASK_RESET   = 33'h1_0000_0000;
   localparam logic [CYCLES_W-1:0] EXPECTED_COUNT_RESET = 5'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ_FIRST,
      ST_READ_SECOND,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic load;
      logic init;
      logic next_start;
      logic begin_walk;
      logic read_first;
      logic read_second;
      logic advance;
      logic close;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic start_visited;
      logic closed;
      logic length_ok;
      logic count_hit;
      logic walk_end;
   } dp_status_type;

endpackage

### hw/rtl/matching_union_cycle_check_top.sv
// Top level of the matching union cycle check: controller, datapath and assertions.
// Load one request per cycle while busy is low: each request writes one vertex's
// partners in both matchings. A request with req_last_vertex set starts the check;
// busy stays high until the result, which is shown for exactly one cycle on
// rsp_valid with rsp_accepted and cannot be held off. The check walks the union
// through the two partner tables, one table read per cycle with registered read
// data: each walk step passes through the states ST_READ_FIRST, ST_READ_SECOND
// and ST_EVAL, and each start vertex through ST_SCAN.
`include "matching_union_cycle_check_top_macros.svh"

module matching_union_cycle_check_top
   import mucc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VERTEX_W-1:0]   req_vertex,
   input  logic [VERTEX_W-1:0]   req_first_partner,
   input  logic [VERTEX_W-1:0]   req_second_partner,
   input  logic                  req_last_vertex,
   output logic                  rsp_valid,
   output logic                  rsp_accepted,
   input  logic                  csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   mucc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_last_vertex(req_last_vertex),
      .status         (status),
      .busy           (busy),
      .cmd            (cmd),
      .rsp_valid      (rsp_valid),
      .rsp_accepted   (rsp_accepted)
   );

   mucc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_vertex        (req_vertex),
      .req_first_partner (req_first_partner),
      .req_second_partner(req_second_partner),
      .cmd               (cmd),
      .status            (status)
   );

   `MUCC_ASSERT_NOW(a_rsp_after_check, rsp_valid, $past(busy), "result without a running check")
   `MUCC_ASSERT_NEXT(a_load_stays_idle, start && !busy && !req_last_vertex, !busy && !rsp_valid, "plain load left idle")
   `MUCC_ASSERT_NEXT(a_last_starts_check, start && !busy && req_last_vertex, busy && !rsp_valid, "last load did not start check")
   `MUCC_ASSERT_NOW(a_single_table_read, busy, $onehot0({cmd.read_first, cmd.read_second, cmd.advance}), "overlapping walk commands")

endmodule

### hw/rtl/mucc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mucc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/mucc_dp.sv
// Datapath: configuration registers, partner tables, walk registers and status.
module mucc_dp
   import mucc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  csr_index_type          csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic [VERTEX_W-1:0]    req_vertex,
   input  logic [VERTEX_W-1:0]    req_first_partner,
   input  logic [VERTEX_W-1:0]    req_second_partner,
   input  dp_cmd_type             cmd,
   output dp_status_type          status
);

   logic [COUNT_W-1:0]      vertex_count_ff, vertex_count_in;
   logic [MASK_W-1:0]       allowed_mask_ff, allowed_mask_in;
   logic [CYCLES_W-1:0]     expected_count_ff, expected_count_in;
   logic [COUNT_W-1:0]      start_ff, start_in;
   logic [VERTEX_W-1:0]     walk_ff, walk_in;
   logic [COUNT_W-1:0]      length_ff, length_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [CYCLES_W-1:0]     cycles_left_ff, cycles_left_in;
   logic                    first_oob_ff, first_oob_in;
   logic                    second_oob_ff, second_oob_in;

   logic [COUNT_W-1:0]  used_count;
   logic                load_in_range;
   logic [VERTEX_W-1:0] first_rd_data, second_rd_data;
   logic [VERTEX_W-1:0] first_value, second_value;
   logic [COUNT_W-1:0]  next_length;

   assign used_count = (vertex_count_ff > COUNT_W'(MAX_VERTICES)) ?
                       COUNT_W'(MAX_VERTICES) : vertex_count_ff;
   assign load_in_range = {1'b0, req_vertex} < COUNT_W'(MAX_VERTICES);

   assign first_value  = first_oob_ff  ? '0 : first_rd_data;
   assign second_value = second_oob_ff ? '0 : second_rd_data;
   assign next_length  = length_ff + COUNT_W'(2);

   mucc_ram #(
      .WIDTH(VERTEX_W),
      .DEPTH(MAX_VERTICES)
   ) u_first_ram (
      .clock  (clock),
      .wr_en  (cmd.load && load_in_range),
      .wr_addr(req_vertex[ADDR_W-1:0]),
      .wr_data(req_first_partner),
      .rd_en  (cmd.read_first),
      .rd_addr(walk_ff[ADDR_W-1:0]),
      .rd_data(first_rd_data)
   );

   mucc_ram #(
      .WIDTH(VERTEX_W),
      .DEPTH(MAX_VERTICES)
   ) u_second_ram (
      .clock  (clock),
      .wr_en  (cmd.load && load_in_range),
      .wr_addr(req_vertex[ADDR_W-1:0]),
      .wr_data(req_second_partner),
      .rd_en  (cmd.read_second),
      .rd_addr(first_value[ADDR_W-1:0]),
      .rd_data(second_rd_data)
   );

   always_comb begin
      vertex_count_in   = vertex_count_ff;
      allowed_mask_in   = allowed_mask_ff;
      expected_count_in = expected_count_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT:   vertex_count_in   = csr_write_data[COUNT_W-1:0];
            CSR_ALLOWED_MASK:   allowed_mask_in   = csr_write_data[MASK_W-1:0];
            CSR_EXPECTED_COUNT: expected_count_in = csr_write_data[CYCLES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      start_in       = start_ff;
      walk_in        = walk_ff;
      length_in      = length_ff;
      visited_in     = visited_ff;
      cycles_left_in = cycles_left_ff;
      first_oob_in   = first_oob_ff;
      second_oob_in  = second_oob_ff;
      if (cmd.init) begin
         start_in       = '0;
         visited_in     = '0;
         cycles_left_in = expected_count_ff;
      end
      if (cmd.next_start) begin
         start_in = start_ff + COUNT_W'(1);
      end
      if (cmd.begin_walk) begin
         walk_in   = start_ff[VERTEX_W-1:0];
         length_in = COUNT_W'(2);
      end
      if (cmd.read_first) begin
         first_oob_in = {1'b0, walk_ff} >= COUNT_W'(MAX_VERTICES);
      end
      if (cmd.read_second) begin
         second_oob_in = {1'b0, first_value} >= COUNT_W'(MAX_VERTICES);
      end
      if (cmd.advance) begin
         walk_in   = second_value;
         length_in = next_length;
         if ({1'b0, second_value} < COUNT_W'(MAX_VERTICES)) begin
            visited_in[second_value[ADDR_W-1:0]] = 1'b1;
         end
      end
      if (cmd.close) begin
         cycles_left_in = cycles_left_ff - CYCLES_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff   <= VERTEX_COUNT_RESET;
         allowed_mask_ff   <= ALLOWED_MASK_RESET;
         expected_count_ff <= EXPECTED_COUNT_RESET;
         visited_ff        <= '0;
         cycles_left_ff    <= '0;
      end else begin
         vertex_count_ff   <= vertex_count_in;
         allowed_mask_ff   <= allowed_mask_in;
         expected_count_ff <= expected_count_in;
         visited_ff        <= visited_in;
         cycles_left_ff    <= cycles_left_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      walk_ff       <= walk_in;
      length_ff     <= length_in;
      first_oob_ff  <= first_oob_in;
      second_oob_ff <= second_oob_in;
   end

   assign status.scan_end      = (start_ff >= used_count) || (used_count < COUNT_W'(2));
   assign status.start_visited = visited_ff[start_ff[ADDR_W-1:0]];
   assign status.closed        = {1'b0, second_value} == start_ff;
   assign status.length_ok     = allowed_mask_ff[length_ff];
   assign status.count_hit     = cycles_left_ff == CYCLES_W'(1);
   assign status.walk_end      = next_length > used_count;

endmodule

### hw/rtl/mucc_ctrl.sv
// Controller state machine: load handshake, cycle walk sequencing and result strobe.
module mucc_ctrl
   import mucc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_last_vertex,
   input  dp_status_type status,
   output logic          busy,
   output dp_cmd_type    cmd,
   output logic          rsp_valid,
   output logic          rsp_accepted
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_accepted_ff, rsp_accepted_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_accepted_ff <= rsp_accepted_in;
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      rsp_valid_in    = 1'b0;
      rsp_accepted_in = rsp_accepted_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_last_vertex) begin
                  cmd.init = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_end) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = 1'b0;
               state_in        = ST_IDLE;
            end else if (status.start_visited) begin
               cmd.next_start = 1'b1;
            end else begin
               cmd.begin_walk = 1'b1;
               state_in       = ST_READ_FIRST;
            end
         end
         ST_READ_FIRST: begin
            cmd.read_first = 1'b1;
            state_in       = ST_READ_SECOND;
         end
         ST_READ_SECOND: begin
            cmd.read_second = 1'b1;
            state_in        = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.closed) begin
               if (!status.length_ok) begin
                  rsp_valid_in    = 1'b1;
                  rsp_accepted_in = 1'b0;
                  state_in        = ST_IDLE;
               end else if (status.count_hit) begin
                  cmd.close       = 1'b1;
                  rsp_valid_in    = 1'b1;
                  rsp_accepted_in = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  cmd.close      = 1'b1;
                  cmd.next_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end else begin
               cmd.advance = 1'b1;
               if (status.walk_end) begin
                  cmd.next_start = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  state_in = ST_READ_FIRST;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy         = state_ff != ST_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;

endmodule

### tb/matching_union_cycle_check_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the matching union cycle check block.
module matching_union_cycle_check_top_tb
   import mucc_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_LOADS = 1000;
   localparam logic [MASK_W-1:0] ALL_LENGTHS = '1;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [VERTEX_W-1:0] first_partner;
      logic [VERTEX_W-1:0] second_partner;
      logic last_vertex;
   } vertex_load_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [VERTEX_W-1:0] req_vertex;
   logic [VERTEX_W-1:0] req_first_partner;
   logic [VERTEX_W-1:0] req_second_partner;
   logic req_last_vertex;
   logic rsp_valid;
   logic rsp_accepted;
   logic csr_write_enable;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   vertex_load_type load_queue[$];
   vertex_load_type next_load;
   bit verdict_queue[$];
   bit expected_verdict;
   int cycle_lengths[$];
   int vertex_order[MAX_VERTICES];

   logic [VERTEX_W-1:0] mdl_first[MAX_VERTICES];
   logic [VERTEX_W-1:0] mdl_second[MAX_VERTICES];
   logic [COUNT_W-1:0] mdl_vertex_count;
   logic [MASK_W-1:0] mdl_length_mask;
   logic [CYCLES_W-1:0] mdl_cycle_target;

   int mismatch_count = 0;
   int idle_cycles = 0;
   int loads_queued = 0;
   int loads_taken = 0;
   int loads_sent = 0;
   int gap_left = 0;
   int burst_left = 1;

   matching_union_cycle_check_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_vertex         (req_vertex),
      .req_first_partner  (req_first_partner),
      .req_second_partner (req_second_partner),
      .req_last_vertex    (req_last_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_accepted       (rsp_accepted),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Walk the union of the two partner tables as the block does.
   function automatic bit union_cycle_verdict();
      int unsigned n;
      int unsigned m;
      int unsigned len;
      logic [31:0] seen;
      logic [CYCLES_W-1:0] left;
      logic [VERTEX_W-1:0] k;
      n = mdl_vertex_count;
      if (n > MAX_VERTICES) n = MAX_VERTICES;
      seen = '0;
      left = mdl_cycle_target;
      for (m = 0; m < n; m++) begin
         if (seen[m]) continue;
         k = VERTEX_W'(m);
         for (len = 2; len <= n; len += 2) begin
            k = mdl_second[mdl_first[k]];
            if (k == VERTEX_W'(m)) begin
               if (!mdl_length_mask[len]) return 1'b0;
               left = left - 1'b1;
               if (left == '0) return 1'b1;
               break;
            end
            seen[k] = 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   function automatic void queue_load(input int v, input int f, input int s, input bit last);
      vertex_load_type item;
      item.vertex = VERTEX_W'(v);
      item.first_partner = VERTEX_W'(f);
      item.second_partner = VERTEX_W'(s);
      item.last_vertex = last;
      load_queue.push_back(item);
      loads_queued++;
   endfunction

   function automatic void shuffle_order(input int n);
      int i;
      int j;
      int tmp;
      for (i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = vertex_order[i];
         vertex_order[i] = vertex_order[j];
         vertex_order[j] = tmp;
      end
   endfunction

   function automatic logic [MASK_W-1:0] random_mask();
      return {1'($urandom_range(0, 1)), 32'($urandom())};
   endfunction

   // Queue matchings whose union has cycle_lengths; a first partner may be broken.
   task automatic queue_matching_sets(input int n, input int sets);
      logic [VERTEX_W-1:0] fp[MAX_VERTICES];
      logic [VERTEX_W-1:0] sp[MAX_VERTICES];
      int base;
      int a;
      int b;
      int nxt;
      int i;
      int j;
      int len;
      int si;
      int r;
      for (si = 0; si < sets; si++) begin
         for (i = 0; i < n; i++) vertex_order[i] = i;
         shuffle_order(n);
         base = 0;
         foreach (cycle_lengths[c]) begin
            len = cycle_lengths[c];
            for (j = 0; j < len; j += 2) begin
               a = vertex_order[base + j];
               b = vertex_order[base + j + 1];
               nxt = vertex_order[base + (j + 2) % len];
               fp[a] = VERTEX_W'(b);
               fp[b] = VERTEX_W'(a);
               sp[b] = VERTEX_W'(nxt);
               sp[nxt] = VERTEX_W'(b);
            end
            base += len;
         end
         if ($urandom_range(0, 3) == 0)
            queue_load($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31), 1'b0);
         if ($urandom_range(0, 7) == 0) begin
            r = $urandom_range(0, n - 1);
            fp[r] = VERTEX_W'($urandom_range(0, 31));
         end
         shuffle_order(n);
         for (i = 0; i < n; i++)
            queue_load(vertex_order[i], fp[vertex_order[i]], sp[vertex_order[i]], i == n - 1);
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (loads_taken != loads_queued || verdict_queue.size() != 0 || busy);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(input int n, input logic [MASK_W-1:0] mask, input int count);
      logic [CSR_DATA_W-1:0] junk;
      wait_idle();
      junk = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom()) : '0;
      write_csr(CSR_VERTEX_COUNT, {junk[CSR_DATA_W-1:COUNT_W], COUNT_W'(n)});
      write_csr(CSR_ALLOWED_MASK, mask);
      write_csr(CSR_EXPECTED_COUNT, {junk[CSR_DATA_W-1:CYCLES_W], CYCLES_W'(count)});
   endtask

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_vertex <= '0;
         req_first_partner <= '0;
         req_second_partner <= '0;
         req_last_vertex <= 1'b0;
      end else if (!start || loads_taken == loads_sent) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (load_queue.size() > 0) begin
            next_load = load_queue.pop_front();
            req_vertex <= next_load.vertex;
            req_first_partner <= next_load.first_partner;
            req_second_partner <= next_load.second_partner;
            req_last_vertex <= next_load.last_vertex;
            start <= 1'b1;
            loads_sent++;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         mdl_vertex_count = VERTEX_COUNT_RESET;
         mdl_length_mask = ALLOWED_MASK_RESET;
         mdl_cycle_target = EXPECTED_COUNT_RESET;
         idle_cycles = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_VERTEX_COUNT: mdl_vertex_count = csr_write_data[COUNT_W-1:0];
               CSR_ALLOWED_MASK: mdl_length_mask = csr_write_data[MASK_W-1:0];
               CSR_EXPECTED_COUNT: mdl_cycle_target = csr_write_data[CYCLES_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            mdl_first[req_vertex] = req_first_partner;
            mdl_second[req_vertex] = req_second_partner;
            if (req_last_vertex) verdict_queue.push_back(union_cycle_verdict());
            loads_taken++;
         end
         if (rsp_valid) begin
            if (verdict_queue.size() == 0) begin
               flag_mismatch("result with no check pending");
            end else begin
               expected_verdict = verdict_queue.pop_front();
               if (rsp_accepted !== expected_verdict)
                  flag_mismatch($sformatf("accepted %b, expected %b",
                                          rsp_accepted, expected_verdict));
            end
         end
         if ((start && !busy) || rsp_valid || csr_write_enable) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int directed_loads;
      int n;
      int vcount;
      int rest;
      int hi;
      int count;
      int si;
      int k;
      logic [MASK_W-1:0] mask;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_VERTEX_COUNT;
      csr_write_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // fill every table entry under the reset settings: one cycle through all vertices
      cycle_lengths.delete();
      cycle_lengths.push_back(32);
      queue_matching_sets(32, 1);

      cycle_lengths.delete();
      cycle_lengths.push_back(2);
      configure(2, MASK_W'(1) << 2, 1);
      queue_matching_sets(2, 1);
      configure(2, '0, 1);
      queue_matching_sets(2, 1);
      configure(2, ALL_LENGTHS, 0);
      queue_matching_sets(2, 1);
      configure(2, ALL_LENGTHS, 31);
      queue_matching_sets(2, 1);

      configure(0, ALL_LENGTHS, 1);
      queue_load(0, 1, 1, 1'b1);
      configure(1, ALL_LENGTHS, 1);
      queue_load(1, 0, 0, 1'b1);
      configure(3, ALL_LENGTHS, 1);
      queue_load(2, 31, 31, 1'b1);
      configure(63, ALL_LENGTHS, 16);
      queue_load(31, 0, 0, 1'b1);

      // tables that are not matchings: a walk that closes at once and one that never closes
      configure(4, ALL_LENGTHS, 2);
      queue_load(0, 1, 2, 1'b0);
      queue_load(1, 2, 0, 1'b0);
      queue_load(2, 3, 3, 1'b0);
      queue_load(3, 0, 1, 1'b1);

      cycle_lengths.push_back(2);
      configure(4, ALL_LENGTHS, 3);
      queue_matching_sets(4, 1);

      directed_loads = loads_queued;
      while (loads_queued - directed_loads < RANDOM_LOADS) begin
         if ($urandom_range(0, 5) == 0) begin
            configure($urandom_range(0, 63), random_mask(), $urandom_range(0, 31));
            for (si = $urandom_range(1, 3); si > 0; si--) begin
               for (k = $urandom_range(0, 12); k > 0; k--)
                  queue_load($urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 31), 1'b0);
               queue_load($urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 31), 1'b1);
            end
         end else begin
            n = ($urandom_range(0, 5) == 0) ? 2 * $urandom_range(9, 16)
                                            : 2 * $urandom_range(1, 8);
            cycle_lengths.delete();
            rest = n;
            while (rest > 0) begin
               hi = rest / 2;
               if ($urandom_range(0, 1) == 1 && hi > 3) hi = 3;
               cycle_lengths.push_back(2 * $urandom_range(1, hi));
               rest -= cycle_lengths[cycle_lengths.size() - 1];
            end
            mask = '0;
            foreach (cycle_lengths[p]) mask[cycle_lengths[p]] = 1'b1;
            count = cycle_lengths.size();
            vcount = n;
            case ($urandom_range(0, 9))
               0: mask[cycle_lengths[$urandom_range(0, cycle_lengths.size() - 1)]] = 1'b0;
               1: mask |= random_mask();
               2: count = $urandom_range(0, 31);
               3: count = $urandom_range(1, count);
               4: vcount = n + $urandom_range(1, 3);
               default: ;
            endcase
            configure(vcount, mask, count);
            queue_matching_sets(n, $urandom_range(1, 4));
         end
      end

      wait_idle();
      repeat (40) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
